### rtl/core/stp_pkg.sv
// shared types, constants and coil lookup for the half-step move controller
`timescale 1ns / 1ps

package stp_pkg;

  localparam int CFG_WIDTH  = 13;
  localparam int BTN_WIDTH  = 6;
  localparam int COIL_WIDTH = 4;
  localparam int POS_WIDTH  = 3;
  localparam int ADDR_WIDTH = 4;
  localparam int DATA_WIDTH = 32;

  localparam logic [CFG_WIDTH-1:0] SHORT_RESET  = 13'd1024;
  localparam logic [CFG_WIDTH-1:0] MEDIUM_RESET = 13'd2048;
  localparam logic [CFG_WIDTH-1:0] LONG_RESET   = 13'd4096;

  // register index, byte address is 4 * index
  typedef enum logic [1:0] {
    REG_SHORT  = 2'd0,
    REG_MEDIUM = 2'd1,
    REG_LONG   = 2'd2
  } reg_idx_t;

  // move lengths as held in the configuration registers
  typedef struct packed {
    logic [CFG_WIDTH-1:0] short_steps;
    logic [CFG_WIDTH-1:0] medium_steps;
    logic [CFG_WIDTH-1:0] long_steps;
  } move_counts_t;

  // half-step coil pattern for each ring position
  function automatic logic [COIL_WIDTH-1:0] coil_lookup(input logic [POS_WIDTH-1:0] pos);
    logic [COIL_WIDTH-1:0] pat;
    case (pos)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h1;
    endcase
    return pat;
  endfunction

endpackage

### rtl/core/stp_cfg_regs.sv
// apb register file holding the three move lengths
`timescale 1ns / 1ps

module stp_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [stp_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [stp_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [stp_pkg::DATA_WIDTH-1:0]   prdata,
  output stp_pkg::move_counts_t            counts
);

  stp_pkg::move_counts_t counts_r;
  stp_pkg::move_counts_t counts_nxt;
  logic                  wr_en;
  logic [1:0]            reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign counts  = counts_r;

  always_comb begin
    counts_nxt = counts_r;
    if (wr_en) begin
      case (reg_idx)
        stp_pkg::REG_SHORT:  counts_nxt.short_steps  = pwdata[stp_pkg::CFG_WIDTH-1:0];
        stp_pkg::REG_MEDIUM: counts_nxt.medium_steps = pwdata[stp_pkg::CFG_WIDTH-1:0];
        stp_pkg::REG_LONG:   counts_nxt.long_steps   = pwdata[stp_pkg::CFG_WIDTH-1:0];
        default:             counts_nxt = counts_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      stp_pkg::REG_SHORT:  prdata = stp_pkg::DATA_WIDTH'(counts_r.short_steps);
      stp_pkg::REG_MEDIUM: prdata = stp_pkg::DATA_WIDTH'(counts_r.medium_steps);
      stp_pkg::REG_LONG:   prdata = stp_pkg::DATA_WIDTH'(counts_r.long_steps);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counts_r.short_steps  <= stp_pkg::SHORT_RESET;
      counts_r.medium_steps <= stp_pkg::MEDIUM_RESET;
      counts_r.long_steps   <= stp_pkg::LONG_RESET;
    end else begin
      counts_r <= counts_nxt;
    end
  end

endmodule

### rtl/core/stp_move_ctrl.sv
// button decode, move state and one half step per tick
`timescale 1ns / 1ps

module stp_move_ctrl #(
  parameter int COUNT_WIDTH = 13
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             advance,
  input  logic [stp_pkg::BTN_WIDTH-1:0]    buttons,
  input  stp_pkg::move_counts_t            counts,
  output logic [stp_pkg::COIL_WIDTH-1:0]   coil_nxt,
  output logic [stp_pkg::CFG_WIDTH-1:0]    steps_left_nxt
);

  localparam int EXT_WIDTH = (COUNT_WIDTH > stp_pkg::CFG_WIDTH) ? COUNT_WIDTH
                                                                : stp_pkg::CFG_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [stp_pkg::POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [COUNT_WIDTH-1:0]        rem_r, rem_nxt;
  logic                          rev_r, rev_nxt;
  logic                          held_r, held_nxt;

  logic [stp_pkg::CFG_WIDTH-1:0] sel_count;
  logic                          sel_rev;
  logic [EXT_WIDTH-1:0]          count_ext;
  logic [COUNT_WIDTH-1:0]        load_count;
  logic [COUNT_WIDTH-1:0]        rem_mid;
  logic                          rev_mid;
  logic [EXT_WIDTH-1:0]          rem_ext;

  // lowest pressed button wins; 0..2 forward, 3..5 reverse
  always_comb begin
    sel_count = counts.short_steps;
    sel_rev   = 1'b0;
    if (buttons[0]) begin
      sel_count = counts.short_steps;
    end else if (buttons[1]) begin
      sel_count = counts.medium_steps;
    end else if (buttons[2]) begin
      sel_count = counts.long_steps;
    end else if (buttons[3]) begin
      sel_count = counts.short_steps;
      sel_rev   = 1'b1;
    end else if (buttons[4]) begin
      sel_count = counts.medium_steps;
      sel_rev   = 1'b1;
    end else begin
      sel_count = counts.long_steps;
      sel_rev   = 1'b1;
    end
  end

  // saturate the loaded count into the counter width
  assign count_ext  = EXT_WIDTH'(sel_count);
  assign load_count = (count_ext > EXT_WIDTH'(COUNT_MAX)) ? COUNT_MAX
                                                          : count_ext[COUNT_WIDTH-1:0];

  always_comb begin
    held_nxt = held_r;
    rem_mid  = rem_r;
    rev_mid  = rev_r;
    if (held_r) begin
      if (buttons == '0) begin
        held_nxt = 1'b0;
      end
    end else if (buttons != '0) begin
      rem_mid  = load_count;
      rev_mid  = sel_rev;
      held_nxt = 1'b1;
    end

    pos_nxt = pos_r;
    rem_nxt = rem_mid;
    rev_nxt = rev_mid;
    if (rem_mid != '0) begin
      pos_nxt = rev_mid ? (pos_r - 3'd1) : (pos_r + 3'd1);
      rem_nxt = rem_mid - COUNT_WIDTH'(1);
    end
  end

  assign rem_ext        = EXT_WIDTH'(rem_nxt);
  assign steps_left_nxt = rem_ext[stp_pkg::CFG_WIDTH-1:0];
  assign coil_nxt       = stp_pkg::coil_lookup(pos_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      rem_r  <= '0;
      rev_r  <= 1'b0;
      held_r <= 1'b0;
    end else if (advance) begin
      pos_r  <= pos_nxt;
      rem_r  <= rem_nxt;
      rev_r  <= rev_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

### rtl/core/stepper_half_step_move_controller_unit.sv
// top level of the half-step stepper move controller
//
//  channel  direction  handshake                  payload
//  in_      input      in_valid / in_ready        in_button_levels[5:0]
//  out_     output     out_valid / out_ready      out_coil_pattern[3:0], out_steps_left[12:0]
//  apb      input      psel, penable, pwrite      paddr[3:0], pwdata, prdata (pready tied high)
//
// one tick per cycle sustained while out_ready stays high; an accepted transaction goes
// into the input register, then through the move logic into the result register
// the move state updates only when a tick moves from the input register to the output
// register, so stalls on out_ready hold both stages and the state in place
// synchronous active-low reset clears the pipeline valids, move state and the move
// lengths (1024, 2048, 4096 half steps)
`timescale 1ns / 1ps

module stepper_half_step_move_controller_unit #(
  parameter int COUNT_WIDTH = 13
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // tick input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [stp_pkg::BTN_WIDTH-1:0]    in_button_levels,
  // coil drive output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [stp_pkg::COIL_WIDTH-1:0]   out_coil_pattern,
  output logic [stp_pkg::CFG_WIDTH-1:0]    out_steps_left,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [stp_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [stp_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [stp_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                             pready
);

  // input stage
  logic                          in_valid_r, in_valid_nxt;
  logic [stp_pkg::BTN_WIDTH-1:0] buttons_r;

  // output stage
  logic                           out_valid_r, out_valid_nxt;
  logic [stp_pkg::COIL_WIDTH-1:0] coil_r;
  logic [stp_pkg::CFG_WIDTH-1:0]  steps_r;

  logic                           advance;
  logic [stp_pkg::COIL_WIDTH-1:0] coil_nxt;
  logic [stp_pkg::CFG_WIDTH-1:0]  steps_nxt;
  stp_pkg::move_counts_t          counts;

  assign pready = 1'b1;

  stp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .counts  (counts)
  );

  // a tick advances when the output register is free or being emptied
  assign advance  = in_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~in_valid_r | advance;

  stp_move_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_move (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .buttons        (buttons_r),
    .counts         (counts),
    .coil_nxt       (coil_nxt),
    .steps_left_nxt (steps_nxt)
  );

  assign in_valid_nxt  = (in_valid & in_ready) | (in_valid_r & ~advance);
  assign out_valid_nxt = advance | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      buttons_r <= in_button_levels;
    end
    if (advance) begin
      coil_r  <= coil_nxt;
      steps_r <= steps_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coil_pattern = coil_r;
  assign out_steps_left   = steps_r;

endmodule

### bench/stepper_move_checker.sv
// checker that predicts and compares coil drive results of the half-step move controller
`timescale 1ns / 1ps

module stepper_move_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [stp_pkg::BTN_WIDTH-1:0]  in_button_levels,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [stp_pkg::COIL_WIDTH-1:0] out_coil_pattern,
  input  logic [stp_pkg::CFG_WIDTH-1:0]  out_steps_left,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [stp_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [stp_pkg::DATA_WIDTH-1:0] pwdata,
  output int                             mismatches,
  output int                             awaited_drives
);

  typedef struct packed {
    logic [stp_pkg::COIL_WIDTH-1:0] coil;
    logic [stp_pkg::CFG_WIDTH-1:0]  steps;
  } drive_word_t;

  // half-step coil order around the ring
  localparam logic [stp_pkg::COIL_WIDTH-1:0] RING_COILS [8] =
    '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

  stp_pkg::move_counts_t          move_len;
  logic [stp_pkg::POS_WIDTH-1:0]  ring_pos;
  logic [stp_pkg::CFG_WIDTH-1:0]  steps_to_go;
  logic                           going_reverse;
  logic                           press_latched;
  drive_word_t                    drive_queue[$];

  // button handling first, then one half step if a move is running
  function automatic drive_word_t next_drive(input logic [stp_pkg::BTN_WIDTH-1:0] lv);
    int                            btn;
    logic [stp_pkg::CFG_WIDTH-1:0] loaded;
    drive_word_t                   w;
    btn = stp_pkg::BTN_WIDTH;
    if (press_latched) begin
      if (lv == '0) press_latched = 1'b0;
    end else if (lv != '0) begin
      for (int i = stp_pkg::BTN_WIDTH - 1; i >= 0; i--) begin
        if (lv[i]) btn = i;
      end
      case (btn % 3)
        0:       loaded = move_len.short_steps;
        1:       loaded = move_len.medium_steps;
        default: loaded = move_len.long_steps;
      endcase
      steps_to_go   = loaded;
      going_reverse = (btn >= 3);
      press_latched = 1'b1;
    end
    if (steps_to_go != '0) begin
      ring_pos    = going_reverse ? ring_pos - 1'b1 : ring_pos + 1'b1;
      steps_to_go = steps_to_go - 1'b1;
    end
    w.coil  = RING_COILS[ring_pos];
    w.steps = steps_to_go;
    return w;
  endfunction

  always @(posedge clk) begin
    drive_word_t want;
    int          bad;
    bad = 0;
    if (!rst_n) begin
      move_len.short_steps  = stp_pkg::SHORT_RESET;
      move_len.medium_steps = stp_pkg::MEDIUM_RESET;
      move_len.long_steps   = stp_pkg::LONG_RESET;
      ring_pos      = '0;
      steps_to_go   = '0;
      going_reverse = 1'b0;
      press_latched = 1'b0;
      drive_queue.delete();
      mismatches     <= 0;
      awaited_drives <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[stp_pkg::ADDR_WIDTH-1:2])
          stp_pkg::REG_SHORT:  move_len.short_steps  = pwdata[stp_pkg::CFG_WIDTH-1:0];
          stp_pkg::REG_MEDIUM: move_len.medium_steps = pwdata[stp_pkg::CFG_WIDTH-1:0];
          stp_pkg::REG_LONG:   move_len.long_steps   = pwdata[stp_pkg::CFG_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) drive_queue.push_back(next_drive(in_button_levels));
      if (out_valid && out_ready) begin
        if (drive_queue.size() == 0) begin
          $display("%0t: unexpected drive transaction, expected none, got coil %h steps %0d",
                   $time, out_coil_pattern, out_steps_left);
          bad++;
        end else begin
          want = drive_queue.pop_front();
          if (out_coil_pattern !== want.coil) begin
            $display("%0t: coil pattern mismatch, expected %h, got %h",
                     $time, want.coil, out_coil_pattern);
            bad++;
          end
          if (out_steps_left !== want.steps) begin
            $display("%0t: steps left mismatch, expected %0d, got %0d",
                     $time, want.steps, out_steps_left);
            bad++;
          end
        end
      end
      mismatches     <= mismatches + bad;
      awaited_drives <= drive_queue.size();
    end
  end

endmodule

### bench/stepper_half_step_move_controller_unit_test.sv
// top of the move controller bench: clock, reset, stimulus, pacing and verdict
`timescale 1ns / 1ps

module stepper_half_step_move_controller_unit_test;

  // generous watchdog bound on the length of the run
  localparam int CYCLE_LIMIT = 200000;
  // byte address past the three move-length registers, writes there must be ignored
  localparam logic [stp_pkg::ADDR_WIDTH-1:0] UNMAPPED_ADDR = 4'hC;
  localparam int SEGMENTS     = 6;
  localparam int SEGMENT_TICKS = 290;

  // hand-picked ticks: every button alone, zero-length moves, a press held
  // through other buttons, lowest button winning, and presses cutting moves short
  localparam logic [stp_pkg::BTN_WIDTH-1:0] DIRECTED_TICKS [22] = '{
    6'h01, 6'h01, 6'h00, 6'h00, 6'h08, 6'h00, 6'h02, 6'h00, 6'h10, 6'h00, 6'h04,
    6'h00, 6'h00, 6'h20, 6'h3F, 6'h00, 6'h3F, 6'h00, 6'h30, 6'h00, 6'h01, 6'h00
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [stp_pkg::BTN_WIDTH-1:0]  in_button_levels = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [stp_pkg::COIL_WIDTH-1:0] out_coil_pattern;
  logic [stp_pkg::CFG_WIDTH-1:0]  out_steps_left;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [stp_pkg::ADDR_WIDTH-1:0] paddr = '0;
  logic [stp_pkg::DATA_WIDTH-1:0] pwdata = '0;
  logic [stp_pkg::DATA_WIDTH-1:0] prdata;
  logic                           pready;

  int mismatches;
  int awaited_drives;
  int cycle_count = 0;
  int ticks_sent = 0;
  int settings_used = 0;
  // idle chances in percent for the tick sender and the drive receiver
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  stepper_half_step_move_controller_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_button_levels (in_button_levels),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_coil_pattern (out_coil_pattern),
    .out_steps_left   (out_steps_left),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // watches both channels and the register port, predicts every drive word
  stepper_move_checker drive_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_button_levels (in_button_levels),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_coil_pattern (out_coil_pattern),
    .out_steps_left   (out_steps_left),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatches       (mismatches),
    .awaited_drives   (awaited_drives)
  );

  always #1 clk = ~clk;

  // receiver stalls at random, one decision per cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one tick transaction; valid only drops during a random gap, so it never
  // gets lowered and raised within the same step
  task automatic send_tick(input logic [stp_pkg::BTN_WIDTH-1:0] lv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_button_levels <= lv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // drop valid and wait until every predicted drive word has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_drives != 0);
    // pipeline is two deep, spare idle cycles cover it
    repeat (4) @(posedge clk);
  endtask

  // setup phase then access phase, then the bus goes idle;
  // junk above the 13 count bits must be dropped
  task automatic register_write(input logic [stp_pkg::ADDR_WIDTH-1:0] addr,
                                input logic [stp_pkg::CFG_WIDTH-1:0]  val);
    logic [stp_pkg::DATA_WIDTH-1:0] noise;
    noise   = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {noise[stp_pkg::DATA_WIDTH-1:stp_pkg::CFG_WIDTH], val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_moves(input logic [stp_pkg::CFG_WIDTH-1:0] s,
                               input logic [stp_pkg::CFG_WIDTH-1:0] m,
                               input logic [stp_pkg::CFG_WIDTH-1:0] l);
    register_write({stp_pkg::REG_SHORT, 2'b00}, s);
    register_write({stp_pkg::REG_MEDIUM, 2'b00}, m);
    register_write({stp_pkg::REG_LONG, 2'b00}, l);
    settings_used++;
  endtask

  // mostly well-formed button use: press, maybe hold with chatter on other
  // buttons, release and let the motor run; the rest is raw level noise
  task automatic move_burst(input int target, input int max_gap);
    int                            first;
    int                            hold;
    int                            gap;
    logic [stp_pkg::BTN_WIDTH-1:0] press;
    first = ticks_sent;
    while (ticks_sent - first < target) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 1) == 0) begin
          press = 6'h01 << $urandom_range(0, stp_pkg::BTN_WIDTH - 1);
        end else begin
          press = stp_pkg::BTN_WIDTH'($urandom_range(1, 63));
        end
        send_tick(press);
        hold = $urandom_range(0, 2);
        repeat (hold) begin
          if ($urandom_range(0, 1) == 0) send_tick(press);
          else send_tick(stp_pkg::BTN_WIDTH'($urandom_range(1, 63)));
        end
        gap = $urandom_range(1, max_gap);
        repeat (gap) send_tick('0);
      end else begin
        repeat ($urandom_range(1, 4)) send_tick(stp_pkg::BTN_WIDTH'($urandom_range(0, 63)));
      end
    end
  endtask

  initial begin
    int                            seg;
    logic [stp_pkg::CFG_WIDTH-1:0] s_len;
    logic [stp_pkg::CFG_WIDTH-1:0] m_len;
    logic [stp_pkg::CFG_WIDTH-1:0] l_len;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first pacing mode: sender idles a quarter of the time, receiver two thirds
    send_idle_pct = 25;
    recv_idle_pct = 67;

    // reset move lengths: long forward, then short reverse cutting it off
    send_tick(6'h04);
    send_tick(6'h00);
    send_tick(6'h08);
    settle();

    // short move, zero-length medium, full-scale long; plus an unmapped write
    program_moves(13'd3, 13'd0, 13'h1FFF);
    register_write(UNMAPPED_ADDR, 13'h0005);
    foreach (DIRECTED_TICKS[i]) send_tick(DIRECTED_TICKS[i]);
    settle();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      // two segments per pacing mode: slow receiver, slow sender, full rate
      case (seg / 2)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // extremes in two segments, small lengths elsewhere so moves finish
      case (seg)
        1: begin
          s_len = 13'd0;
          m_len = 13'h1FFF;
          l_len = 13'd5;
        end
        3: begin
          s_len = 13'h1FFF;
          m_len = 13'd0;
          l_len = 13'd1;
        end
        default: begin
          s_len = stp_pkg::CFG_WIDTH'($urandom_range(0, (seg == 2) ? 40 : 15));
          m_len = stp_pkg::CFG_WIDTH'($urandom_range(0, (seg == 2) ? 40 : 15));
          l_len = stp_pkg::CFG_WIDTH'($urandom_range(0, (seg == 2) ? 40 : 15));
        end
      endcase
      program_moves(s_len, m_len, l_len);
      move_burst(SEGMENT_TICKS, (seg == 2) ? 44 : 18);
      settle();
    end

    $display("covered %0d button ticks over %0d move-length settings", ticks_sent,
             settings_used);
    $display("pacing ran with a slow receiver, a slow sender and at full rate");
    if (mismatches == 0 && awaited_drives == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
